/* rtl/cmp_pkg.sv */
package cmp_pkg;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CMDLEN = 4'd1,
        PH_CMD    = 4'd2,
        PH_RET    = 4'd3,
        PH_ARGC   = 4'd4,
        PH_ATYPE  = 4'd5,
        PH_ILEN   = 4'd6,
        PH_IDIG   = 4'd7,
        PH_SLEN   = 4'd8,
        PH_SBYTE  = 4'd9
    } t_phase;

    typedef enum logic [3:0] {
        K_CMDLEN  = 4'd0,
        K_CMDBYTE = 4'd1,
        K_RET     = 4'd2,
        K_ARGC    = 4'd3,
        K_VOID    = 4'd4,
        K_INT     = 4'd5,
        K_SLEN    = 4'd6,
        K_SBYTE   = 4'd7,
        K_ERROR   = 4'd8
    } t_kind;

    localparam logic [1:0] CFG_VOID_CODE = 2'd0;
    localparam logic [1:0] CFG_INT_CODE  = 2'd1;
    localparam logic [1:0] CFG_STR_CODE  = 2'd2;

    localparam logic [7:0] VOID_CODE_RST = 8'd0;
    localparam logic [7:0] INT_CODE_RST  = 8'd1;
    localparam logic [7:0] STR_CODE_RST  = 8'd2;

    localparam logic [7:0]  CHAR_MINUS = 8'h2D;
    localparam logic [31:0] CHAR_ZERO  = 32'h0000_0030;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
    } t_item;

    typedef struct packed {
        t_kind        kind;
        logic [31:0]  value;
        logic [30:0]  arg_index;
        logic         message_end;
    } t_result;

endpackage

/* rtl/cmp_in_stage.sv */
module cmp_in_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cmp_pkg::t_item i_item,
    input  logic           i_take,
    output logic           o_valid,
    output cmp_pkg::t_item o_item
);
    import cmp_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  load;

    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/cmp_parse.sv */
module cmp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_index,
    input  logic [7:0]       i_cfg_data,
    input  logic             i_step,
    input  cmp_pkg::t_item   i_item,
    output logic             o_res_valid,
    output cmp_pkg::t_result o_res
);
    import cmp_pkg::*;

    logic [7:0]  r_void_code;
    logic [7:0]  r_int_code;
    logic [7:0]  r_str_code;

    t_phase      r_phase,     n_phase;
    logic [1:0]  r_wbc,       n_wbc;
    logic [31:0] r_wacc,      n_wacc;
    logic [31:0] r_cmd_rem,   n_cmd_rem;
    logic [31:0] r_args_rem,  n_args_rem;
    logic [30:0] r_cur_arg,   n_cur_arg;
    logic [7:0]  r_int_rem,   n_int_rem;
    logic        r_int_first, n_int_first;
    logic        r_int_neg,   n_int_neg;
    logic [31:0] r_int_acc,   n_int_acc;
    logic [7:0]  r_str_rem,   n_str_rem;
    logic [31:0] r_consumed,  n_consumed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_void_code <= VOID_CODE_RST;
            r_int_code  <= INT_CODE_RST;
            r_str_code  <= STR_CODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_VOID_CODE: r_void_code <= i_cfg_data;
                CFG_INT_CODE:  r_int_code  <= i_cfg_data;
                CFG_STR_CODE:  r_str_code  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        logic        fs;
        logic [7:0]  b;
        logic [31:0] word;
        logic [31:0] digit;
        logic [31:0] acc;
        logic        fin;
        t_kind       fin_kind;
        logic        ad;
        t_kind       ad_kind;
        logic [31:0] ad_value;
        logic [31:0] args_dec;

        fs       = i_item.frame_start;
        b        = i_item.data_byte;
        fin      = 1'b0;
        fin_kind = K_ERROR;
        ad       = 1'b0;
        ad_kind  = K_VOID;
        ad_value = 32'd0;
        args_dec = 32'd0;
        word     = 32'd0;
        digit    = {{24{b[7]}}, b} - CHAR_ZERO;
        acc      = 32'd0;

        n_phase     = r_phase;
        n_wbc       = r_wbc;
        n_wacc      = r_wacc;
        n_cmd_rem   = r_cmd_rem;
        n_args_rem  = r_args_rem;
        n_cur_arg   = r_cur_arg;
        n_int_rem   = r_int_rem;
        n_int_first = r_int_first;
        n_int_neg   = r_int_neg;
        n_int_acc   = r_int_acc;
        n_str_rem   = r_str_rem;
        n_consumed  = r_consumed;

        o_res_valid       = 1'b0;
        o_res.kind        = K_ERROR;
        o_res.value       = 32'd0;
        o_res.arg_index   = 31'd0;
        o_res.message_end = 1'b0;

        if (i_step && fs) begin
            n_phase     = PH_CMDLEN;
            n_wbc       = 2'd0;
            n_wacc      = 32'd0;
            n_cmd_rem   = 32'd0;
            n_args_rem  = 32'd0;
            n_cur_arg   = 31'd0;
            n_int_rem   = 8'd0;
            n_int_first = 1'b0;
            n_int_neg   = 1'b0;
            n_int_acc   = 32'd0;
            n_str_rem   = 8'd0;
            n_consumed  = 32'd0;
        end

        if (i_step && n_phase != PH_IDLE) begin
            n_consumed = n_consumed + 32'd1;
            word       = n_wacc | ({24'd0, b} << {n_wbc, 3'b000});
            case (n_phase)
                PH_CMDLEN: begin
                    n_wacc = word;
                    if (n_wbc == 2'd3) begin
                        n_wbc = 2'd0;
                        if (word[31]) begin
                            fin      = 1'b1;
                            fin_kind = K_ERROR;
                        end else begin
                            n_cmd_rem         = word;
                            n_phase           = (word != 32'd0) ? PH_CMD : PH_RET;
                            o_res_valid       = 1'b1;
                            o_res.kind        = K_CMDLEN;
                            o_res.value       = word;
                            o_res.arg_index   = n_cur_arg;
                        end
                    end else begin
                        n_wbc = n_wbc + 2'd1;
                    end
                end
                PH_CMD: begin
                    n_cmd_rem = n_cmd_rem - 32'd1;
                    if (n_cmd_rem == 32'd0) begin
                        n_phase = PH_RET;
                    end
                    o_res_valid     = 1'b1;
                    o_res.kind      = K_CMDBYTE;
                    o_res.value     = {24'd0, b};
                    o_res.arg_index = n_cur_arg;
                end
                PH_RET: begin
                    n_phase         = PH_ARGC;
                    n_wbc           = 2'd0;
                    n_wacc          = 32'd0;
                    o_res_valid     = 1'b1;
                    o_res.kind      = K_RET;
                    o_res.value     = {24'd0, b};
                    o_res.arg_index = n_cur_arg;
                end
                PH_ARGC: begin
                    n_wacc = word;
                    if (n_wbc == 2'd3) begin
                        n_wbc      = 2'd0;
                        n_args_rem = word;
                        if (word == 32'd0 || word[31]) begin
                            fin      = 1'b1;
                            fin_kind = K_ARGC;
                        end else begin
                            n_phase         = PH_ATYPE;
                            o_res_valid     = 1'b1;
                            o_res.kind      = K_ARGC;
                            o_res.value     = word;
                            o_res.arg_index = n_cur_arg;
                        end
                    end else begin
                        n_wbc = n_wbc + 2'd1;
                    end
                end
                PH_ATYPE: begin
                    if (b == r_void_code) begin
                        ad       = 1'b1;
                        ad_kind  = K_VOID;
                        ad_value = {24'd0, b};
                    end else if (b == r_int_code) begin
                        n_phase = PH_ILEN;
                    end else if (b == r_str_code) begin
                        n_phase = PH_SLEN;
                    end else begin
                        fin      = 1'b1;
                        fin_kind = K_ERROR;
                    end
                end
                PH_ILEN: begin
                    n_int_acc   = 32'd0;
                    n_int_neg   = 1'b0;
                    n_int_first = 1'b1;
                    if (b == 8'd0) begin
                        ad       = 1'b1;
                        ad_kind  = K_INT;
                        ad_value = 32'd0;
                    end else begin
                        n_int_rem = b;
                        n_phase   = PH_IDIG;
                    end
                end
                PH_IDIG: begin
                    if (n_int_first && b == CHAR_MINUS) begin
                        n_int_neg = 1'b1;
                    end else begin
                        n_int_acc = (n_int_acc << 3) + (n_int_acc << 1) + digit;
                    end
                    n_int_first = 1'b0;
                    n_int_rem   = n_int_rem - 8'd1;
                    if (n_int_rem == 8'd0) begin
                        acc      = n_int_acc;
                        ad       = 1'b1;
                        ad_kind  = K_INT;
                        ad_value = n_int_neg ? (32'd0 - acc) : acc;
                    end
                end
                PH_SLEN: begin
                    n_str_rem = b;
                    if (b == 8'd0) begin
                        ad       = 1'b1;
                        ad_kind  = K_SLEN;
                        ad_value = 32'd0;
                    end else begin
                        n_phase         = PH_SBYTE;
                        o_res_valid     = 1'b1;
                        o_res.kind      = K_SLEN;
                        o_res.value     = {24'd0, b};
                        o_res.arg_index = n_cur_arg;
                    end
                end
                PH_SBYTE: begin
                    n_str_rem = n_str_rem - 8'd1;
                    if (n_str_rem == 8'd0) begin
                        ad       = 1'b1;
                        ad_kind  = K_SBYTE;
                        ad_value = {24'd0, b};
                    end else begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = K_SBYTE;
                        o_res.value     = {24'd0, b};
                        o_res.arg_index = n_cur_arg;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase

            if (ad) begin
                args_dec   = n_args_rem - 32'd1;
                n_args_rem = args_dec;
                if (args_dec == 32'd0) begin
                    fin      = 1'b1;
                    fin_kind = ad_kind;
                end else begin
                    o_res_valid     = 1'b1;
                    o_res.kind      = ad_kind;
                    o_res.value     = ad_value;
                    o_res.arg_index = n_cur_arg;
                    n_cur_arg       = n_cur_arg + 31'd1;
                    n_phase         = PH_ATYPE;
                end
            end

            if (fin) begin
                n_phase           = PH_IDLE;
                o_res_valid       = 1'b1;
                o_res.kind        = fin_kind;
                o_res.value       = n_consumed;
                o_res.arg_index   = n_cur_arg;
                o_res.message_end = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_wbc       <= 2'd0;
            r_wacc      <= 32'd0;
            r_cmd_rem   <= 32'd0;
            r_args_rem  <= 32'd0;
            r_cur_arg   <= 31'd0;
            r_int_rem   <= 8'd0;
            r_int_first <= 1'b0;
            r_int_neg   <= 1'b0;
            r_int_acc   <= 32'd0;
            r_str_rem   <= 8'd0;
            r_consumed  <= 32'd0;
        end else begin
            r_phase     <= n_phase;
            r_wbc       <= n_wbc;
            r_wacc      <= n_wacc;
            r_cmd_rem   <= n_cmd_rem;
            r_args_rem  <= n_args_rem;
            r_cur_arg   <= n_cur_arg;
            r_int_rem   <= n_int_rem;
            r_int_first <= n_int_first;
            r_int_neg   <= n_int_neg;
            r_int_acc   <= n_int_acc;
            r_str_rem   <= n_str_rem;
            r_consumed  <= n_consumed;
        end
    end

`ifndef SYNTHESIS
    a_no_result_without_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |-> !o_res_valid)
        else $error("result without a processed byte");

    a_error_ends_message: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == K_ERROR |-> o_res.message_end)
        else $error("error record without message end");

    a_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.message_end |->
            o_res.kind != K_CMDLEN && o_res.kind != K_CMDBYTE && o_res.kind != K_RET)
        else $error("message end on a header record");

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.message_end |=> r_phase == PH_IDLE)
        else $error("parser not idle after message end");
`endif

endmodule

/* rtl/cmp_out_stage.sv */
module cmp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  cmp_pkg::t_result i_res,
    input  logic             i_out_ready,
    output logic             o_free,
    output logic             o_valid,
    output cmp_pkg::t_result o_res
);
    import cmp_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    assign o_free = !r_valid || i_out_ready;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

/* rtl/call_message_parser.sv */
// channel   direction  handshake                    payload
// in        to block   i_in_valid / o_in_ready      i_data_byte, i_frame_start
// out       from block o_out_valid / i_out_ready    o_kind, o_value, o_arg_index,
//                                                   o_message_end
// cfg       to block   i_cfg_we                     i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while each record is taken; a record leaves through
// the input register, the parse logic and the result register.
// A byte that yields no record is consumed all the same.
// While the result register holds an untaken record, the parse step stalls and the
// input side takes at most one more byte into the empty input register.
// Reset (synchronous, active low) sets the type codes to 0/1/2 and idles the parser.
module call_message_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_data_byte,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [3:0]         o_kind,
    output logic signed [31:0] o_value,
    output logic [30:0]        o_arg_index,
    output logic               o_message_end
);
    import cmp_pkg::*;

    t_item   in_item;
    t_item   q_item;
    logic    q_valid;
    logic    out_free;
    logic    step;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign in_item.data_byte   = i_data_byte;
    assign in_item.frame_start = i_frame_start;
    assign step                = q_valid && out_free;

    cmp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .i_take  (step),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cmp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_item      (q_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    cmp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (res_valid),
        .i_res       (res),
        .i_out_ready (i_out_ready),
        .o_free      (out_free),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_kind        = out_res.kind;
    assign o_value       = out_res.value;
    assign o_arg_index   = out_res.arg_index;
    assign o_message_end = out_res.message_end;

endmodule
